// ===== rtl/rtpext_pkg.sv =====
// Shared constants and payload types for the RTP one-byte extension finder.
package rtpext_pkg;

  localparam logic [15:0] MaxPacketBytes = 16'd2048;
  localparam logic [15:0] OneByteProfile = 16'hBEDE;
  localparam logic [6:0]  FixedHdrBytes  = 7'd12;
  localparam logic [3:0]  StopId         = 4'hF;
  localparam logic [3:0]  PadId          = 4'h0;
  localparam logic [3:0]  TargetIdReset  = 4'd1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  ext_byte;
    logic [31:0] ext_word;
    logic [15:0] element_offset;
    logic [6:0]  audio_level;
    logic        voice_flag;
  } out_t;

endpackage

// ===== rtl/rtpext_parser.sv =====
// Per-packet parse state and the header and extension element walk.
module rtpext_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  rtpext_pkg::in_t    item,
  input  logic [3:0]         target_id,
  output rtpext_pkg::out_t   result
);

  logic [15:0] byte_position, byte_position_next;
  logic [3:0]  csrc_count, csrc_count_next;
  logic        has_extension, has_extension_next;
  logic [15:0] profile_word, profile_word_next;
  logic [17:0] extension_bytes, extension_bytes_next;
  logic [16:0] next_element_position, next_element_position_next;
  logic        walk_active, walk_active_next;
  logic        match_seen, match_seen_next;
  logic [31:0] captured_word, captured_word_next;
  logic [1:0]  capture_remaining, capture_remaining_next;
  logic [15:0] match_offset, match_offset_next;

  logic [7:0]  b;
  logic [3:0]  id;
  logic [16:0] pos17;
  logic [15:0] hlen;
  logic [7:0]  ext_start;
  logic [18:0] ext_end;
  logic [16:0] elem_cand;
  logic        in_range;
  logic        stop_walk;
  logic [16:0] pkt_len;
  logic [18:0] ext_end_next;
  logic        ok;
  logic [7:0]  eb;

  assign b         = item.data_byte;
  assign id        = b[7:4];
  assign pos17     = {1'b0, byte_position};
  assign hlen      = {9'd0, rtpext_pkg::FixedHdrBytes + {1'b0, csrc_count, 2'b00}};
  assign ext_start = 8'(hlen) + 8'd4;
  assign ext_end   = {11'd0, ext_start} + {1'b0, extension_bytes};
  assign in_range  = byte_position < rtpext_pkg::MaxPacketBytes;
  assign elem_cand = (id == rtpext_pkg::PadId) ? pos17 + 17'd1
                                               : pos17 + 17'd2 + {13'd0, b[3:0]};
  assign stop_walk = ({3'd0, byte_position} >= ext_end) || (id == rtpext_pkg::StopId);

  always_comb begin
    byte_position_next         = byte_position;
    csrc_count_next            = csrc_count;
    has_extension_next         = has_extension;
    profile_word_next          = profile_word;
    extension_bytes_next       = extension_bytes;
    next_element_position_next = next_element_position;
    walk_active_next           = walk_active;
    match_seen_next            = match_seen;
    captured_word_next         = captured_word;
    capture_remaining_next     = capture_remaining;
    match_offset_next          = match_offset;

    if (in_range) begin
      byte_position_next = byte_position + 16'd1;
      if (byte_position == 16'd0) begin
        csrc_count_next    = b[3:0];
        has_extension_next = b[4];
      end else begin
        if (has_extension) begin
          if (byte_position == hlen) begin
            profile_word_next = {b, 8'h00};
          end else if (byte_position == hlen + 16'd1) begin
            profile_word_next = profile_word | {8'h00, b};
          end else if (byte_position == hlen + 16'd2) begin
            extension_bytes_next = {b, 10'd0};
          end else if (byte_position == hlen + 16'd3) begin
            extension_bytes_next = extension_bytes | {8'd0, b, 2'b00};
            if (profile_word == rtpext_pkg::OneByteProfile) begin
              walk_active_next           = 1'b1;
              next_element_position_next = {9'd0, ext_start};
            end
          end
        end
        if (capture_remaining != 2'd0) begin
          capture_remaining_next = capture_remaining - 2'd1;
          case (capture_remaining)
            2'd3:    captured_word_next = captured_word | {8'h00, b, 16'h0000};
            2'd2:    captured_word_next = captured_word | {16'h0000, b, 8'h00};
            default: captured_word_next = captured_word | {24'h000000, b};
          endcase
        end
        if (walk_active && pos17 == next_element_position) begin
          if (stop_walk) begin
            walk_active_next = 1'b0;
          end else if (id != rtpext_pkg::PadId && id == target_id) begin
            walk_active_next       = 1'b0;
            match_seen_next        = 1'b1;
            match_offset_next      = byte_position;
            captured_word_next     = {b, 24'h000000};
            capture_remaining_next = 2'd3;
          end else begin
            next_element_position_next = elem_cand;
            if ({2'd0, elem_cand} >= ext_end || elem_cand[16]) begin
              walk_active_next = 1'b0;
            end
          end
        end
      end
    end
  end

  assign pkt_len      = in_range ? pos17 + 17'd1 : {1'b0, rtpext_pkg::MaxPacketBytes};
  assign ext_end_next = {12'd0, rtpext_pkg::FixedHdrBytes} + {13'd0, csrc_count_next, 2'b00}
                        + 19'd4 + {1'b0, extension_bytes_next};
  assign ok = match_seen_next && has_extension_next
              && profile_word_next == rtpext_pkg::OneByteProfile
              && pkt_len >= {10'd0, rtpext_pkg::FixedHdrBytes}
              && {2'd0, pkt_len} > ext_end_next;
  assign eb = captured_word_next[23:16];

  always_comb begin
    result = '0;
    if (ok) begin
      result.found          = 1'b1;
      result.ext_byte       = eb;
      result.ext_word       = captured_word_next;
      result.element_offset = match_offset_next;
      result.audio_level    = eb[6:0];
      result.voice_flag     = eb[7];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.last_byte)) begin
      byte_position         <= '0;
      csrc_count            <= '0;
      has_extension         <= 1'b0;
      profile_word          <= '0;
      extension_bytes       <= '0;
      next_element_position <= '0;
      walk_active           <= 1'b0;
      match_seen            <= 1'b0;
      captured_word         <= '0;
      capture_remaining     <= '0;
      match_offset          <= '0;
    end else if (step) begin
      byte_position         <= byte_position_next;
      csrc_count            <= csrc_count_next;
      has_extension         <= has_extension_next;
      profile_word          <= profile_word_next;
      extension_bytes       <= extension_bytes_next;
      next_element_position <= next_element_position_next;
      walk_active           <= walk_active_next;
      match_seen            <= match_seen_next;
      captured_word         <= captured_word_next;
      capture_remaining     <= capture_remaining_next;
      match_offset          <= match_offset_next;
    end
  end

`ifndef SYNTHESIS
  a_match_ends_walk: assert property (@(posedge clk) disable iff (rst)
    match_seen |-> !walk_active)
    else $error("walk still active after match");

  a_capture_needs_match: assert property (@(posedge clk) disable iff (rst)
    capture_remaining != 2'd0 |-> match_seen)
    else $error("word capture without match");

  a_position_saturates: assert property (@(posedge clk) disable iff (rst)
    byte_position <= rtpext_pkg::MaxPacketBytes)
    else $error("byte position past saturation point");
`endif

endmodule

// ===== rtl/rtp_one_byte_extension_finder_top.sv =====
// Top level: input register, configuration register and result register.
// Accepts one packet byte per cycle with no gaps between packets. Each byte is
// parsed from the input register into the parser state registers; the result of
// a packet is loaded into the result register when its last byte leaves the
// input register. The only stall comes from the output side: while the result
// register holds a result that has not been taken, a further last byte waits,
// and bytes in the middle of a packet keep flowing. target_id may be written
// only between packets, with no transaction in flight.
module rtp_one_byte_extension_finder_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rtpext_pkg::in_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rtpext_pkg::out_t  out_data,
  input  logic              cfg_wr_en,
  input  logic [3:0]        cfg_wr_data
);

  logic              s0_valid;
  rtpext_pkg::in_t   s0_item;
  logic              step;
  logic [3:0]        target_id;
  rtpext_pkg::out_t  result;

  assign step     = s0_valid && (!s0_item.last_byte || !out_valid || out_ready);
  assign in_ready = !s0_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_id <= rtpext_pkg::TargetIdReset;
    end else if (cfg_wr_en) begin
      target_id <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_ready) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s0_item <= in_data;
    end
  end

  rtpext_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (s0_item),
    .target_id (target_id),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && s0_item.last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && s0_item.last_byte) begin
      out_data <= result;
    end
  end

`ifndef SYNTHESIS
  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data.ext_word == 32'd0
      && out_data.element_offset == 16'd0 && out_data.ext_byte == 8'd0)
    else $error("fields not cleared on miss");

  a_level_from_word: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.ext_byte == out_data.ext_word[23:16]
      && {out_data.voice_flag, out_data.audio_level} == out_data.ext_byte)
    else $error("level fields disagree with captured word");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !(step && s0_item.last_byte))
    else $error("result register overwritten before taken");
`endif

endmodule

// ===== tb/sv/rtp_ext_lookup_sb_pkg.sv =====
// Scoreboard class that predicts and checks RTP one-byte extension lookups.
`timescale 1ns / 100ps
package rtp_ext_lookup_sb_pkg;

  class ext_lookup_scoreboard;
    logic [3:0]  target_id;
    logic [15:0] byte_pos;
    logic [3:0]  csrc_cnt;
    logic        has_ext;
    logic [15:0] profile;
    logic [17:0] ext_bytes;
    logic [17:0] next_elem_pos;
    logic        walking;
    logic        matched;
    logic [31:0] captured_word;
    logic [2:0]  capture_left;
    logic [15:0] match_offset;
    rtpext_pkg::out_t lookup_q[$];
    int          mismatches;
    int          lookups_checked;

    function new();
      target_id = rtpext_pkg::TargetIdReset;
      mismatches = 0;
      lookups_checked = 0;
      clear_packet();
    endfunction

    function void clear_packet();
      byte_pos = '0;
      csrc_cnt = '0;
      has_ext = 1'b0;
      profile = '0;
      ext_bytes = '0;
      next_elem_pos = '0;
      walking = 1'b0;
      matched = 1'b0;
      captured_word = '0;
      capture_left = '0;
      match_offset = '0;
    endfunction

    function void add_lookup(rtpext_pkg::out_t want);
      lookup_q.insert(lookup_q.size(), want);
    endfunction

    function void parse_byte(int unsigned pos, logic [7:0] b);
      int unsigned hdr_len;
      int unsigned ext_start;
      int unsigned ext_end;
      logic [3:0]  id;
      hdr_len = int'(rtpext_pkg::FixedHdrBytes) + 4 * int'(csrc_cnt);
      ext_start = hdr_len + 4;
      ext_end = ext_start + int'(ext_bytes);
      if (pos == 0) begin
        csrc_cnt = b[3:0];
        has_ext = b[4];
        return;
      end
      if (has_ext) begin
        if (pos == hdr_len) begin
          profile = {b, 8'h00};
        end else if (pos == hdr_len + 1) begin
          profile[7:0] = profile[7:0] | b;
        end else if (pos == hdr_len + 2) begin
          ext_bytes = {b, 10'b0};
        end else if (pos == hdr_len + 3) begin
          ext_bytes = ext_bytes | {8'h00, b, 2'b00};
          if (profile == rtpext_pkg::OneByteProfile) begin
            walking = 1'b1;
            next_elem_pos = 18'(ext_start);
          end
        end
      end
      if (capture_left != 0) begin
        captured_word = captured_word | (32'(b) << (8 * (int'(capture_left) - 1)));
        capture_left = capture_left - 3'd1;
      end
      if (walking && pos == int'(next_elem_pos)) begin
        id = b[7:4];
        if (pos >= ext_end || id == rtpext_pkg::StopId) begin
          walking = 1'b0;
        end else if (id == rtpext_pkg::PadId) begin
          next_elem_pos = 18'(pos + 1);
        end else if (id == target_id) begin
          matched = 1'b1;
          walking = 1'b0;
          match_offset = 16'(pos);
          captured_word = {b, 24'h000000};
          capture_left = 3'd3;
        end else begin
          next_elem_pos = 18'(pos + 2 + int'(b[3:0]));
        end
        if (walking && (int'(next_elem_pos) >= ext_end || next_elem_pos > 18'h0FFFF)) begin
          walking = 1'b0;
        end
      end
    endfunction

    function void note_byte(rtpext_pkg::in_t item);
      int unsigned pos;
      int unsigned pkt_len;
      int unsigned ext_end;
      logic [7:0]  lvl_byte;
      rtpext_pkg::out_t want;
      pos = byte_pos;
      if (pos < int'(rtpext_pkg::MaxPacketBytes)) begin
        parse_byte(pos, item.data_byte);
        byte_pos = 16'(pos + 1);
        pkt_len = pos + 1;
      end else begin
        pkt_len = rtpext_pkg::MaxPacketBytes;
      end
      if (!item.last_byte) return;
      ext_end = int'(rtpext_pkg::FixedHdrBytes) + 4 * int'(csrc_cnt) + 4 + int'(ext_bytes);
      want = '0;
      if (matched && has_ext && profile == rtpext_pkg::OneByteProfile &&
          pkt_len >= int'(rtpext_pkg::FixedHdrBytes) && pkt_len > ext_end) begin
        lvl_byte = captured_word[23:16];
        want.found = 1'b1;
        want.ext_byte = lvl_byte;
        want.ext_word = captured_word;
        want.element_offset = match_offset;
        want.audio_level = lvl_byte[6:0];
        want.voice_flag = lvl_byte[7];
      end
      add_lookup(want);
      clear_packet();
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 200)
          $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_lookup(rtpext_pkg::out_t got);
      rtpext_pkg::out_t want;
      if (lookup_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 200)
          $display("%0t unexpected result: expected none actual %h", $time, got);
        return;
      end
      want = lookup_q.pop_front();
      lookups_checked++;
      check_field("found", 32'(want.found), 32'(got.found));
      check_field("ext_byte", 32'(want.ext_byte), 32'(got.ext_byte));
      check_field("ext_word", want.ext_word, got.ext_word);
      check_field("element_offset", 32'(want.element_offset), 32'(got.element_offset));
      check_field("audio_level", 32'(want.audio_level), 32'(got.audio_level));
      check_field("voice_flag", 32'(want.voice_flag), 32'(got.voice_flag));
    endfunction
  endclass

endpackage

// ===== tb/sv/tb_rtp_one_byte_extension_finder_top.sv =====
// Testbench top: drives RTP packets byte by byte and checks each extension lookup.
`timescale 1ns / 100ps
module tb_rtp_one_byte_extension_finder_top;

  localparam int CycleLimit = 400000;
  localparam int RandomBytes = 660;
  localparam int HoldCycles = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  rtpext_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rtpext_pkg::out_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [3:0] cfg_wr_data = rtpext_pkg::TargetIdReset;

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   hold_req = 1'b0;
  int   bytes_sent = 0;
  logic [7:0] pkt[$];
  logic [3:0] target_plan [12] = '{4'd14, 4'd1, 4'd7, 4'd0, 4'd15, 4'd2,
                                   4'd9, 4'd14, 4'd5, 4'd1, 4'd12, 4'd3};
  rtp_ext_lookup_sb_pkg::ext_lookup_scoreboard sb;

  rtp_one_byte_extension_finder_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_byte(in_data);
      if (out_valid && out_ready) sb.check_lookup(out_data);
    end
  end

  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL rtp_one_byte_extension_finder_top");
    $finish;
  end

  function automatic void append_byte(input logic [7:0] value);
    pkt.insert(pkt.size(), value);
  endfunction

  task automatic drive_byte(input logic [7:0] b, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_byte: b, last_byte: last};
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_packet();
    foreach (pkt[i]) drive_byte(pkt[i], i == pkt.size() - 1);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.lookup_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_target(input logic [3:0] value);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.target_id = value;
  endtask

  task automatic build_noise_packet();
    pkt.delete();
    repeat ($urandom_range(1, 16)) append_byte(8'($urandom));
  endtask

  task automatic build_lookup_packet(input logic [3:0] tgt, input int payload_max);
    int cc;
    int words;
    int ext_len;
    int base;
    int roll;
    int elen;
    int cut;
    logic [7:0] hdr0;
    logic [3:0] id;
    pkt.delete();
    cc = ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(2);
    hdr0 = 8'($urandom_range(255));
    hdr0[3:0] = cc[3:0];
    hdr0[4] = ($urandom_range(9) != 0);
    append_byte(hdr0);
    repeat (11 + 4 * cc) append_byte(8'($urandom));
    if ($urandom_range(9) != 0) begin
      append_byte(rtpext_pkg::OneByteProfile[15:8]);
      append_byte(rtpext_pkg::OneByteProfile[7:0]);
    end else begin
      append_byte(8'($urandom));
      append_byte(8'($urandom));
    end
    words = ($urandom_range(15) == 0) ? $urandom_range(65535) : $urandom_range(5);
    append_byte(words[15:8]);
    append_byte(words[7:0]);
    ext_len = (words * 4 < 24) ? words * 4 : 24;
    base = pkt.size();
    while (pkt.size() < base + ext_len) begin
      roll = $urandom_range(99);
      if (roll < 20) begin
        append_byte({rtpext_pkg::PadId, 4'($urandom_range(15))});
      end else if (roll < 25) begin
        append_byte({rtpext_pkg::StopId, 4'($urandom_range(15))});
      end else begin
        elen = ($urandom_range(5) == 0) ? $urandom_range(15) : $urandom_range(2);
        id = (roll < 60) ? tgt : 4'($urandom_range(1, 14));
        append_byte({id, 4'(elen)});
        repeat (elen + 1) append_byte(8'($urandom));
      end
    end
    while (pkt.size() > base + ext_len) void'(pkt.pop_back());
    if ($urandom_range(3) != 0) repeat ($urandom_range(payload_max)) append_byte(8'($urandom));
    if ($urandom_range(9) == 0) begin
      cut = $urandom_range(1, pkt.size());
      while (pkt.size() > cut) void'(pkt.pop_back());
    end
  endtask

  task automatic run_traffic(input int byte_budget);
    int stop_at;
    stop_at = bytes_sent + byte_budget;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(9) < 7) build_lookup_packet(sb.target_id, 10);
      else build_noise_packet();
      send_packet();
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    pkt = '{8'hFF};
    send_packet();
    // match on the last element of the block; the word runs past the packet end
    pkt = '{8'h90, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
            8'h00, 8'hBE, 8'hDE, 8'h00, 8'h01, 8'h00, 8'h0F, 8'h00, 8'h10, 8'hFF};
    send_packet();
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 26 : (ph == 1) ? 64 : 0;
      recv_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 26 : 0;
      for (int st = 0; st < 4; st++) begin
        write_target(target_plan[ph * 4 + st]);
        if (ph == 2 && st == 0) begin
          // hold the output while short packets pile up at the input
          @(posedge clk);
          hold_req = 1'b1;
          repeat (30) begin
            build_noise_packet();
            send_packet();
          end
        end
        run_traffic(RandomBytes / 12);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.lookup_q.size() == 0) begin
      $display("PASS rtp_one_byte_extension_finder_top");
    end else begin
      $display("FAIL rtp_one_byte_extension_finder_top");
    end
    $finish;
  end

endmodule
